// ===== rtl/core/lbp_pkg.sv =====
// Shared types and constants for the LSB-first bit packer.
// No dependencies; imported by every module of the packer.
package lbp_pkg;

	// Input command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_ALIGN = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	// Register map
	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_CHUNK_SIZE = 3'd0;
	localparam logic [15:0] CHUNK_SIZE_RESET = 16'd1024;

	// Decoupling queue depth
	localparam int unsigned QUEUE_DEPTH = 2;

	// One unit of work for the back end: up to eight bytes of one item
	typedef struct packed {
		logic [63:0] bytes;
		logic [3:0] nbytes;
		logic force_end;
		logic marker;
	} lbp_entry_t;

endpackage

// ===== rtl/core/lbp_front.sv =====
// Front end of the bit packer: accepts items, merges them with the partial byte.
// Depends on lbp_pkg; pushes byte groups into the decoupling queue.
module lbp_front (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic [1:0] command,
	input  logic [6:0] bit_count,
	input  logic [63:0] bit_value,
	input  logic queue_full,
	output logic push,
	output lbp_pkg::lbp_entry_t push_entry
);
	import lbp_pkg::*;

	logic [6:0] partial_q;
	logic [2:0] bit_pos_q;
	logic accept;
	logic [6:0] count_clamped;
	logic [63:0] value_masked;
	logic [71:0] stream;
	logic [6:0] total_bits;
	logic [3:0] write_bytes;
	logic [7:0] tail_byte;

	assign item_stall = queue_full;
	assign accept = item_valid && !item_stall;

	// Clamp the count, drop the bits above it, and splice after the partial byte
	assign count_clamped = bit_count[6] ? 7'd64 : bit_count;
	assign value_masked = bit_value & ~({64{1'b1}} << count_clamped);
	assign stream = ({8'b0, value_masked} << bit_pos_q) | {65'b0, partial_q};
	assign total_bits = {4'b0, bit_pos_q} + count_clamped;
	assign write_bytes = total_bits[6:3];
	assign tail_byte = stream[{write_bytes, 3'b000} +: 8];

	// Classify the item into a queue entry
	always_comb begin
		push = 1'b0;
		push_entry.bytes = stream[63:0];
		push_entry.nbytes = write_bytes;
		push_entry.force_end = 1'b0;
		push_entry.marker = 1'b0;
		case (command)
			CMD_WRITE: begin
				push = accept && (write_bytes != 4'd0);
			end
			CMD_ALIGN: begin
				push = accept && (bit_pos_q != 3'd0);
				push_entry.bytes = {57'b0, partial_q};
				push_entry.nbytes = 4'd1;
			end
			CMD_FLUSH: begin
				push = accept;
				push_entry.bytes = {57'b0, partial_q};
				push_entry.nbytes = 4'd1;
				push_entry.force_end = (bit_pos_q != 3'd0);
				push_entry.marker = (bit_pos_q == 3'd0);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Hold the leftover bits between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			bit_pos_q <= '0;
		end else if (accept) begin
			case (command)
				CMD_WRITE: begin
					partial_q <= tail_byte[6:0];
					bit_pos_q <= total_bits[2:0];
				end
				CMD_ALIGN, CMD_FLUSH: begin
					partial_q <= '0;
					bit_pos_q <= '0;
				end
				default: begin
					partial_q <= partial_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/lbp_queue.sv =====
// Short queue between the front and back ends of the bit packer.
// Depends on lbp_pkg for the entry type and depth.
module lbp_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  lbp_pkg::lbp_entry_t push_entry,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output lbp_pkg::lbp_entry_t head
);
	import lbp_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	lbp_entry_t slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = slots_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/lbp_back.sv =====
// Back end of the bit packer: emits queued bytes one per beat with chunk marks.
// Depends on lbp_pkg; fed by lbp_queue, drives the result channel registers.
module lbp_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [15:0] chunk_size,
	input  logic q_not_empty,
	input  lbp_pkg::lbp_entry_t q_head,
	output logic q_pop,
	output logic result_valid,
	input  logic result_stall,
	output logic [7:0] out_byte,
	output logic byte_valid,
	output logic chunk_end,
	output logic last
);
	import lbp_pkg::*;

	logic busy_q;
	logic [3:0] remain_q;
	logic [63:0] bytes_q;
	logic force_q;
	logic marker_q;
	logic [15:0] chunk_fill_q;
	logic result_valid_q;
	logic [7:0] out_byte_q;
	logic byte_valid_q;
	logic chunk_end_q;
	logic last_q;
	logic slot_free;
	logic fire;
	logic final_beat;
	logic size_reached;
	logic end_now;

	assign slot_free = !result_valid_q || !result_stall;
	assign fire = busy_q && slot_free;
	assign final_beat = (remain_q == 4'd1);
	assign q_pop = q_not_empty && (!busy_q || (fire && final_beat));
	assign size_reached = ({1'b0, chunk_fill_q} + 17'd1) >= {1'b0, chunk_size};
	assign end_now = force_q || marker_q || size_reached;

	assign result_valid = result_valid_q;
	assign out_byte = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign chunk_end = chunk_end_q;
	assign last = last_q;

	// Load the next entry and step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			remain_q <= '0;
			force_q <= 1'b0;
			marker_q <= 1'b0;
			chunk_fill_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				remain_q <= q_head.nbytes;
				force_q <= q_head.force_end;
				marker_q <= q_head.marker;
			end else if (fire) begin
				remain_q <= remain_q - 1'b1;
				if (final_beat) begin
					busy_q <= 1'b0;
				end
			end
			// Count bytes toward the chunk
			if (fire) begin
				chunk_fill_q <= end_now ? 16'd0 : chunk_fill_q + 16'd1;
			end
			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Shift out bytes and hold the result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			bytes_q <= q_head.bytes;
		end else if (fire) begin
			bytes_q <= {8'b0, bytes_q[63:8]};
		end
		if (fire) begin
			out_byte_q <= marker_q ? 8'd0 : bytes_q[7:0];
			byte_valid_q <= !marker_q;
			chunk_end_q <= end_now;
			last_q <= final_beat;
		end
	end

endmodule

// ===== rtl/core/lsb_first_bit_packer_top.sv =====
// Top level of the LSB-first bit packer: register port, front, queue and back.
// Depends on lbp_pkg, lbp_front, lbp_queue and lbp_back.
//
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------
// item     | item_valid / item_stall   | command, bit_count, bit_value
// result   | result_valid / result_stall | out_byte, byte_valid, chunk_end, last
// config   | psel penable pwrite pready | paddr, pwdata, prdata (chunk_size @ 0)
//
// Each item is classified in its accepting cycle and queued as up to eight bytes; its
// first result passes through the queue slot, the back end's byte register and the
// result registers. The back end sends one beat per cycle unless the result side stalls,
// with no gap between queued items. The queue holds two byte groups behind the
// one being sent, so under a result stall the front accepts until both slots fill.
// Reset clears the partial byte, chunk fill and queue; chunk_size returns to 1024.
module lsb_first_bit_packer_top (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic [1:0] command,
	input  logic [6:0] bit_count,
	input  logic [63:0] bit_value,
	output logic result_valid,
	input  logic result_stall,
	output logic [7:0] out_byte,
	output logic byte_valid,
	output logic chunk_end,
	output logic last,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [lbp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lbp_pkg::*;

	logic [15:0] chunk_size_q;
	logic reg_write;
	logic push;
	lbp_entry_t push_entry;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	lbp_entry_t q_head;

	// Register port
	assign pready = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;
	assign prdata = (paddr[PADDR_W-1:2] == ADDR_CHUNK_SIZE[PADDR_W-1:2]) ?
		{16'b0, chunk_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RESET;
		end else if (reg_write && (paddr[PADDR_W-1:2] == ADDR_CHUNK_SIZE[PADDR_W-1:2])) begin
			chunk_size_q <= pwdata[15:0];
		end
	end

	lbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.command    (command),
		.bit_count  (bit_count),
		.bit_value  (bit_value),
		.queue_full (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	lbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	lbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.chunk_size   (chunk_size_q),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.chunk_end    (chunk_end),
		.last         (last)
	);

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for lsb_first_bit_packer_top: queue-fed item driver, result monitor and
// an in-bench bit-packing predictor; chunk_size is set over the APB-style port.
// Depends on lbp_pkg and lsb_first_bit_packer_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lbp_pkg::*;

	// Reserved command code; the block must ignore it
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] count;
		logic [63:0] value;
	} packer_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic data_valid;
		logic chunk_end;
		logic last;
	} stream_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] command = '0;
	logic [6:0] bit_count = '0;
	logic [63:0] bit_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [7:0] out_byte;
	logic byte_valid;
	logic chunk_end;
	logic last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Predictor state: partial byte, its fill, bytes in the current chunk, chunk size
	logic [7:0] part_bits = '0;
	int part_len = 0;
	logic [15:0] chunk_cnt = '0;
	logic [15:0] chunk_len = CHUNK_SIZE_RESET;

	packer_item_t send_q[$];
	stream_beat_t due_stream[$];
	int errors = 0;
	int items_sent = 0;
	int beats_seen = 0;
	bit item_taken = 1'b0;
	bit hold_off = 1'b0;

	lsb_first_bit_packer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.command(command),
		.bit_count(bit_count),
		.bit_value(bit_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.chunk_end(chunk_end),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			flag_mismatch($sformatf("beat %0d %s got %0h want %0h", beats_seen, name, got, want));
		end
	endtask

	// Emit one data byte and advance the chunk count
	function automatic void emit_stream_byte(input logic [7:0] data, input logic force_end);
		stream_beat_t b;
		b.data = data;
		b.data_valid = 1'b1;
		b.last = 1'b0;
		if (force_end || ({16'd0, chunk_cnt} + 32'd1 >= {16'd0, chunk_len})) begin
			b.chunk_end = 1'b1;
			chunk_cnt = '0;
		end else begin
			b.chunk_end = 1'b0;
			chunk_cnt = chunk_cnt + 16'd1;
		end
		due_stream.push_back(b);
	endfunction

	// Predict the stream beats caused by one accepted item
	function automatic void pack_item(input packer_item_t it);
		int n;
		int i;
		int first;
		stream_beat_t b;
		first = due_stream.size();
		case (it.cmd)
			CMD_WRITE: begin
				n = (it.count > 7'd64) ? 64 : int'(it.count);
				for (i = 0; i < n; i++) begin
					part_bits[part_len] = it.value[i];
					part_len++;
					if (part_len == 8) begin
						emit_stream_byte(part_bits, 1'b0);
						part_bits = '0;
						part_len = 0;
					end
				end
			end
			CMD_ALIGN: begin
				if (part_len > 0) begin
					emit_stream_byte(part_bits, 1'b0);
					part_bits = '0;
					part_len = 0;
				end
			end
			CMD_FLUSH: begin
				if (part_len > 0) begin
					emit_stream_byte(part_bits, 1'b1);
					part_bits = '0;
					part_len = 0;
				end else begin
					b.data = 8'h00;
					b.data_valid = 1'b0;
					b.chunk_end = 1'b1;
					b.last = 1'b0;
					due_stream.push_back(b);
				end
				chunk_cnt = '0;
			end
			default: begin
			end
		endcase
		// Mark the final beat of this item
		if (due_stream.size() > first) begin
			b = due_stream.pop_back();
			b.last = 1'b1;
			due_stream.push_back(b);
		end
	endfunction

	task automatic queue_item(input logic [1:0] cmd, input logic [6:0] count,
			input logic [63:0] value);
		packer_item_t it;
		it.cmd = cmd;
		it.count = count;
		it.value = value;
		send_q.push_back(it);
	endtask

	function automatic packer_item_t random_item();
		packer_item_t it;
		int r;
		r = $urandom_range(99);
		if (r < 70) it.cmd = CMD_WRITE;
		else if (r < 82) it.cmd = CMD_ALIGN;
		else if (r < 92) it.cmd = CMD_FLUSH;
		else it.cmd = CMD_IGNORED;
		it.value = {$urandom, $urandom};
		r = $urandom_range(9);
		if (r == 0) it.count = 7'($urandom_range(127, 65));
		else if (r == 1) it.count = 7'd64;
		else it.count = 7'($urandom_range(64));
		return it;
	endfunction

	// Write chunk_size through a setup and an access cycle, then read it back
	task automatic set_chunk_size(input logic [31:0] word);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_CHUNK_SIZE;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		chunk_len = word[15:0];
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("chunk_size readback", {16'd0, prdata[15:0]}, {16'd0, chunk_len});
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Wait until every item is taken and every predicted beat has arrived
	task automatic settle();
		int guard;
		guard = 0;
		while ((send_q.size() > 0 || item_valid || due_stream.size() > 0) && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		if (due_stream.size() > 0) begin
			flag_mismatch($sformatf("%0d predicted beats never arrived", due_stream.size()));
			due_stream.delete();
		end
		// let items that cause no beat drain out of the block
		repeat (24) @(posedge clk);
	endtask

	// Item side: record an accepted beat and predict its results
	always @(posedge clk) begin : take_item
		packer_item_t it;
		if (arst_n && item_valid && !item_stall) begin
			it.cmd = command;
			it.count = bit_count;
			it.value = bit_value;
			pack_item(it);
			items_sent++;
			item_taken = 1'b1;
		end
	end

	// Item side: hold a stalled beat, else offer the next one or idle
	always @(negedge clk) begin : drive_item
		packer_item_t nxt;
		bit calm;
		calm = (items_sent >= 120 && items_sent < 170);
		if (arst_n && (!item_valid || item_taken)) begin
			if (send_q.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
				nxt = send_q.pop_front();
				item_valid <= 1'b1;
				command <= nxt.cmd;
				bit_count <= nxt.count;
				bit_value <= nxt.value;
			end else begin
				item_valid <= 1'b0;
			end
		end
		item_taken = 1'b0;
	end

	// Result side: stall at random, or solidly during the hold-off
	always @(negedge clk) begin : drive_stall
		bit calm;
		calm = (beats_seen >= 300 && beats_seen < 450);
		result_stall <= hold_off || (!calm && $urandom_range(99) < 10);
	end

	// Hold off the result side long enough for the block to back up
	initial begin : backpressure
		while (items_sent < 60) @(posedge clk);
		hold_off = 1'b1;
		repeat (80) @(posedge clk);
		hold_off = 1'b0;
	end

	// Result side: compare each beat with the oldest prediction
	always @(posedge clk) begin : watch_stream
		stream_beat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (due_stream.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat, out_byte %0h", out_byte));
			end else begin
				want = due_stream.pop_front();
				check_field("out_byte", {24'd0, out_byte}, {24'd0, want.data});
				check_field("byte_valid", {31'd0, byte_valid}, {31'd0, want.data_valid});
				check_field("chunk_end", {31'd0, chunk_end}, {31'd0, want.chunk_end});
				check_field("last", {31'd0, last}, {31'd0, want.last});
			end
			beats_seen++;
		end
	end

	initial begin : stimulus
		logic [31:0] sizes [8];
		int p;
		int j;
		sizes[0] = 32'd1;
		sizes[1] = 32'd0;
		sizes[2] = 32'd3;
		sizes[3] = 32'd65535;
		sizes[4] = 32'hbeef_0007;
		sizes[5] = 32'd300;
		sizes[6] = 32'd2;
		sizes[7] = 32'd1024;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty writes, empty align and flush, long and clipped counts
		queue_item(CMD_WRITE, 7'd0, '1);
		queue_item(CMD_ALIGN, 7'd0, 64'd0);
		queue_item(CMD_FLUSH, 7'd0, 64'd0);
		queue_item(CMD_WRITE, 7'd64, '1);
		queue_item(CMD_WRITE, 7'd3, 64'hffff_ffff_ffff_fffd);
		queue_item(CMD_WRITE, 7'd64, 64'ha5a5_0f0f_3c3c_9669);
		queue_item(CMD_ALIGN, 7'h7f, '1);
		queue_item(CMD_WRITE, 7'd127, 64'h0123_4567_89ab_cdef);
		queue_item(CMD_WRITE, 7'd65, 64'h8000_0000_0000_0001);
		queue_item(CMD_IGNORED, 7'd64, '1);
		queue_item(CMD_WRITE, 7'd1, 64'd1);
		queue_item(CMD_IGNORED, 7'd7, 64'h7f);
		queue_item(CMD_FLUSH, 7'h7f, '1);
		queue_item(CMD_WRITE, 7'd7, 64'h7f);
		queue_item(CMD_WRITE, 7'd1, 64'd1);
		queue_item(CMD_WRITE, 7'd8, 64'd0);
		queue_item(CMD_WRITE, 7'd63, '1);
		queue_item(CMD_WRITE, 7'd1, 64'd0);
		queue_item(CMD_ALIGN, 7'd0, 64'd0);
		queue_item(CMD_WRITE, 7'd5, 64'h1f);
		queue_item(CMD_FLUSH, 7'd0, 64'd0);
		queue_item(CMD_FLUSH, 7'd0, 64'd0);
		settle();

		// Random phases over a range of chunk sizes, extremes included
		for (p = 0; p < 8; p++) begin
			set_chunk_size(sizes[p]);
			for (j = 0; j < 25; j++) send_q.push_back(random_item());
			// fill the chunk well past the next, smaller size
			if (chunk_len == 16'd300) begin
				for (j = 0; j < 10; j++) queue_item(CMD_WRITE, 7'd64, {$urandom, $urandom});
			end
			settle();
		end

		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/lbp_pkg.sv
rtl/core/lbp_front.sv
rtl/core/lbp_queue.sv
rtl/core/lbp_back.sv
rtl/core/lsb_first_bit_packer_top.sv
tb/sv/tb.sv
